[design/aars_pkg.sv]
// Shared types, constants, mount table and smoothing function for the accelerometer remap smoother.
package aars_pkg;

	localparam int AccelW = 27;
	localparam int RawW   = 12;
	localparam int SettleW = 4;

	localparam logic signed [AccelW-1:0] REST_G = 27'sd9806550;
	localparam logic signed [AccelW-1:0] SCALE  = 27'sd19153;

	// floor(d/11) = (d * RECIP11) >> RECIP_SH for d < 2**27
	localparam logic [57:0] RECIP11  = 58'd195225787;
	localparam int          RECIP_SH = 31;

	typedef enum logic [1:0] {
		CMD_SAMPLE = 2'd0,
		CMD_PAUSE  = 2'd1,
		CMD_RESUME = 2'd2,
		CMD_CLEAR  = 2'd3
	} cmd_t;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_SLEEP = 2'd1;

	localparam logic REG_MOUNT  = 1'b0;
	localparam logic REG_SETTLE = 1'b1;

	localparam logic [1:0] AXIS_X = 2'd0;
	localparam logic [1:0] AXIS_Y = 2'd1;
	localparam logic [1:0] AXIS_Z = 2'd2;

	typedef struct packed {
		logic [1:0] src;
		logic       neg;
	} mount_sel_t;

	localparam mount_sel_t MOUNT_TAB [8][3] = '{
		'{'{AXIS_X, 1'b1}, '{AXIS_Y, 1'b1}, '{AXIS_Z, 1'b0}},
		'{'{AXIS_Y, 1'b1}, '{AXIS_X, 1'b0}, '{AXIS_Z, 1'b0}},
		'{'{AXIS_X, 1'b0}, '{AXIS_Y, 1'b0}, '{AXIS_Z, 1'b0}},
		'{'{AXIS_Y, 1'b0}, '{AXIS_X, 1'b1}, '{AXIS_Z, 1'b0}},
		'{'{AXIS_X, 1'b0}, '{AXIS_Y, 1'b1}, '{AXIS_Z, 1'b1}},
		'{'{AXIS_Y, 1'b0}, '{AXIS_X, 1'b0}, '{AXIS_Z, 1'b1}},
		'{'{AXIS_X, 1'b1}, '{AXIS_Y, 1'b0}, '{AXIS_Z, 1'b1}},
		'{'{AXIS_Y, 1'b1}, '{AXIS_X, 1'b1}, '{AXIS_Z, 1'b1}}
	};

	function automatic logic signed [AccelW-1:0] smooth(
		input logic signed [AccelW-1:0] st,
		input logic signed [AccelW-1:0] nv
	);
		logic signed [AccelW:0]   d;
		logic [AccelW-1:0]        mag;
		logic [57:0]              prod;
		logic [AccelW-1:0]        q;
		logic signed [AccelW-1:0] step;
		d    = (AccelW+1)'(nv) - (AccelW+1)'(st);
		mag  = d[AccelW] ? AccelW'(-d) : AccelW'(d);
		prod = 58'(mag) * RECIP11;
		q    = prod[RECIP_SH +: AccelW];
		step = d[AccelW] ? -$signed(q) : $signed(q);
		return st + step;
	endfunction

endpackage

[design/accel_axis_remap_smoother.sv]
// Top level: axis remap, scaling and X/Y exponential smoothing of accelerometer beats.
// A sample beat goes through stage 1 and then the result register to the result port.
// Throughput: one beat per cycle while result_stall is low; stage 1 holds the remapped,
// scaled vector, the result register the smoothed one: a beat enters while a result waits.
// Pause, resume and clear beats update filter state in stage 1 and give no result.
// Reset (arst_n low) clears the filter to rest, running, mount 0 and settle count 1.
module accel_axis_remap_smoother (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [3:0]  cfg_data,
	input  logic        sample_valid,
	output logic        sample_stall,
	input  logic [1:0]  command,
	input  logic [1:0]  link_status,
	input  logic [15:0] raw_x,
	input  logic [15:0] raw_y,
	input  logic [15:0] raw_z,
	output logic        result_valid,
	input  logic        result_stall,
	output logic signed [26:0] accel_x,
	output logic signed [26:0] accel_y,
	output logic signed [26:0] accel_z,
	output logic        wake_request
);

	localparam int W = aars_pkg::AccelW;

	logic [2:0]                          mount_q;
	logic [aars_pkg::SettleW-1:0]        settle_count_q;

	logic                                valid_s1;
	aars_pkg::cmd_t                      cmd_s1;
	logic                                wake_s1;
	logic signed [W-1:0]                 nv_x_s1, nv_y_s1, nv_z_s1;

	logic signed [W-1:0]                 filt_x_q, filt_y_q, last_z_q;
	logic                                paused_q;
	logic [aars_pkg::SettleW-1:0]        settle_left_q;

	logic                                result_valid_q;
	logic signed [W-1:0]                 accel_x_q, accel_y_q, accel_z_q;
	logic                                wake_q;

	logic                                out_free, adv_s1, sample_s1, take_in;
	logic signed [aars_pkg::RawW-1:0]    sx, sy, sz;
	logic signed [W-1:0]                 nv [3];
	logic signed [W-1:0]                 filt_x_d, filt_y_d;
	logic                                at_rest, load_new;

	function automatic logic signed [aars_pkg::RawW-1:0] pick(
		input logic [1:0]                       src,
		input logic signed [aars_pkg::RawW-1:0] a,
		input logic signed [aars_pkg::RawW-1:0] b,
		input logic signed [aars_pkg::RawW-1:0] c
	);
		logic signed [aars_pkg::RawW-1:0] r;
		unique case (src)
			aars_pkg::AXIS_X: r = a;
			aars_pkg::AXIS_Y: r = b;
			aars_pkg::AXIS_Z: r = c;
			default:          r = '0;
		endcase
		return r;
	endfunction

	// Configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mount_q        <= 3'd0;
			settle_count_q <= 4'd1;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aars_pkg::REG_MOUNT:  mount_q        <= cfg_data[2:0];
				aars_pkg::REG_SETTLE: settle_count_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Handshake
	assign out_free     = !result_valid_q || !result_stall;
	assign sample_s1    = valid_s1 && (cmd_s1 == aars_pkg::CMD_SAMPLE);
	assign adv_s1       = valid_s1 && (!sample_s1 || out_free);
	assign sample_stall = valid_s1 && !adv_s1;
	assign take_in      = sample_valid && !sample_stall;

	// Remap and scale; rest vector when the link status is not OK
	always_comb begin
		sx = $signed(raw_x[aars_pkg::RawW-1:0]);
		sy = $signed(raw_y[aars_pkg::RawW-1:0]);
		sz = $signed(raw_z[aars_pkg::RawW-1:0]);
		for (int i = 0; i < 3; i++) begin
			nv[i] = W'(pick(aars_pkg::MOUNT_TAB[mount_q][i].src, sx, sy, sz)) * aars_pkg::SCALE;
			if (aars_pkg::MOUNT_TAB[mount_q][i].neg)
				nv[i] = -nv[i];
		end
		if (link_status != aars_pkg::STAT_OK) begin
			nv[0] = '0;
			nv[1] = '0;
			nv[2] = aars_pkg::REST_G;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in || adv_s1) begin
			valid_s1 <= take_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			cmd_s1  <= aars_pkg::cmd_t'(command);
			wake_s1 <= (link_status == aars_pkg::STAT_SLEEP);
			nv_x_s1 <= nv[0];
			nv_y_s1 <= nv[1];
			nv_z_s1 <= nv[2];
		end
	end

	// Filter
	always_comb begin
		at_rest  = (filt_x_q == '0) && (filt_y_q == '0) && (last_z_q == aars_pkg::REST_G);
		load_new = at_rest || (!paused_q && (settle_left_q == '0));
		filt_x_d = load_new ? nv_x_s1 : aars_pkg::smooth(filt_x_q, nv_x_s1);
		filt_y_d = load_new ? nv_y_s1 : aars_pkg::smooth(filt_y_q, nv_y_s1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filt_x_q      <= '0;
			filt_y_q      <= '0;
			last_z_q      <= aars_pkg::REST_G;
			paused_q      <= 1'b0;
			settle_left_q <= '0;
		end else if (adv_s1) begin
			unique case (cmd_s1)
				aars_pkg::CMD_PAUSE: begin
					paused_q <= 1'b1;
				end
				aars_pkg::CMD_RESUME: begin
					paused_q      <= 1'b0;
					settle_left_q <= settle_count_q;
				end
				aars_pkg::CMD_CLEAR: begin
					filt_x_q <= '0;
					filt_y_q <= '0;
					last_z_q <= aars_pkg::REST_G;
				end
				aars_pkg::CMD_SAMPLE: begin
					filt_x_q <= filt_x_d;
					filt_y_q <= filt_y_d;
					last_z_q <= nv_z_s1;
					if (!load_new && !paused_q)
						settle_left_q <= settle_left_q - 4'd1;
				end
				default: ;
			endcase
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (adv_s1 && sample_s1) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sample_s1) begin
			accel_x_q <= filt_x_d;
			accel_y_q <= filt_y_d;
			accel_z_q <= nv_z_s1;
			wake_q    <= wake_s1;
		end
	end

	assign result_valid = result_valid_q;
	assign accel_x      = accel_x_q;
	assign accel_y      = accel_y_q;
	assign accel_z      = accel_z_q;
	assign wake_request = wake_q;

	a_empty_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> !sample_stall)
		else $error("input stalled with stage 1 empty");

	a_sample_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		sample_s1 && !result_valid_q |=> result_valid_q)
		else $error("sample beat in stage 1 did not reach result register");

	a_paused_settle_hold: assert property (@(posedge clk) disable iff (!arst_n)
		paused_q && !(adv_s1 && cmd_s1 == aars_pkg::CMD_RESUME)
		|=> settle_left_q == $past(settle_left_q))
		else $error("settle count moved while paused");

	a_clear_rest: assert property (@(posedge clk) disable iff (!arst_n)
		adv_s1 && cmd_s1 == aars_pkg::CMD_CLEAR
		|=> filt_x_q == '0 && filt_y_q == '0 && last_z_q == aars_pkg::REST_G)
		else $error("clear did not return filter to rest");

endmodule
